// ===== rtl/swp_pkg.sv =====
// Package for the weighted index picker: transaction types, command codes,
// generator constants and the controller/datapath interface structs.
// No dependencies; every other file imports it.
package swp_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int ADDR_W          = 3;
	localparam int ACTIVE_W        = 5;

	localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
	localparam int          SHIFT_MIX1  = 30;
	localparam int          SHIFT_MIX2  = 27;
	localparam int          SHIFT_MIX3  = 31;
	localparam int          SHIFT_TOP   = 40;
	localparam int          FRAC_BITS   = 24;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_DRAW  = 2'd1,
		KIND_SEED  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot;
		logic [15:0] weight;
		logic [63:0] seed_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0] picked_index;
		logic       empty_table;
	} out_item_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_WRITE,
		DP_SEED,
		DP_INIT,
		DP_SUM,
		DP_ADVANCE,
		DP_LOAD_MIX1,
		DP_LOAD_MIX2,
		DP_LOAD_U,
		DP_MUL,
		DP_SCAN,
		DP_EMIT_EMPTY,
		DP_EMIT_PICK
	} dp_op_t;

	typedef enum logic [1:0] {
		MB_MIX_A,
		MB_MIX_B,
		MB_TOTAL
	} mul_b_t;

	localparam logic [1:0] MSTEP_LO      = 2'd0;
	localparam logic [1:0] MSTEP_CROSS_A = 2'd1;
	localparam logic [1:0] MSTEP_CROSS_B = 2'd2;

	typedef struct packed {
		dp_op_t     op;
		mul_b_t     mb;
		logic [1:0] mstep;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic at_last;
		logic total_zero;
		logic scan_stop;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_TEST,
		ST_EMPTY,
		ST_ADV,
		ST_MIX1,
		ST_MUL_A,
		ST_MIX2,
		ST_MUL_B,
		ST_MIX3,
		ST_MUL_T,
		ST_SCAN_INIT,
		ST_SCAN
	} state_t;

endpackage

// ===== rtl/swp_ctrl.sv =====
// Controller state machine of the weighted index picker.
// Depends on swp_pkg; drives the datapath in swp_dp through dp_cmd_t.
module swp_ctrl import swp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  kind_t      kind,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy
);

	state_t     state_q, state_d;
	logic [1:0] mstep_q;
	logic       in_mul;
	logic       mul_done;

	assign in_mul   = (state_q == ST_MUL_A) || (state_q == ST_MUL_B) || (state_q == ST_MUL_T);
	assign mul_done = (mstep_q == MSTEP_CROSS_B);
	assign busy     = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= MSTEP_LO;
		end else begin
			state_q <= state_d;
			if (in_mul && !mul_done) begin
				mstep_q <= mstep_q + 2'd1;
			end else begin
				mstep_q <= MSTEP_LO;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && kind == KIND_DRAW) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (status.n_zero) state_d = ST_EMPTY;
				else if (status.at_last) state_d = ST_TEST;
			end
			ST_TEST: begin
				state_d = status.total_zero ? ST_EMPTY : ST_ADV;
			end
			ST_EMPTY:     state_d = ST_IDLE;
			ST_ADV:       state_d = ST_MIX1;
			ST_MIX1:      state_d = ST_MUL_A;
			ST_MUL_A: begin
				if (mul_done) state_d = ST_MIX2;
			end
			ST_MIX2:      state_d = ST_MUL_B;
			ST_MUL_B: begin
				if (mul_done) state_d = ST_MIX3;
			end
			ST_MIX3:      state_d = ST_MUL_T;
			ST_MUL_T: begin
				if (mul_done) state_d = ST_SCAN_INIT;
			end
			ST_SCAN_INIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (status.scan_stop) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = DP_NOP;
		cmd.mb    = MB_MIX_A;
		cmd.mstep = mstep_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_WRITE: cmd.op = DP_WRITE;
						KIND_DRAW:  cmd.op = DP_INIT;
						KIND_SEED:  cmd.op = DP_SEED;
						default:    cmd.op = DP_NOP;
					endcase
				end
			end
			ST_SUM:       cmd.op = status.n_zero ? DP_NOP : DP_SUM;
			ST_TEST:      cmd.op = DP_NOP;
			ST_EMPTY:     cmd.op = DP_EMIT_EMPTY;
			ST_ADV:       cmd.op = DP_ADVANCE;
			ST_MIX1:      cmd.op = DP_LOAD_MIX1;
			ST_MUL_A: begin
				cmd.op = DP_MUL;
				cmd.mb = MB_MIX_A;
			end
			ST_MIX2:      cmd.op = DP_LOAD_MIX2;
			ST_MUL_B: begin
				cmd.op = DP_MUL;
				cmd.mb = MB_MIX_B;
			end
			ST_MIX3:      cmd.op = DP_LOAD_U;
			ST_MUL_T: begin
				cmd.op = DP_MUL;
				cmd.mb = MB_TOTAL;
			end
			ST_SCAN_INIT: cmd.op = DP_INIT;
			ST_SCAN:      cmd.op = status.scan_stop ? DP_EMIT_PICK : DP_SCAN;
			default:      cmd.op = DP_NOP;
		endcase
	end

endmodule

// ===== rtl/swp_dp.sv =====
// Datapath of the weighted index picker: weight table, generator state,
// shared 32x32 multiplier, sum and scan registers, result register.
// Depends on swp_pkg; commanded by swp_ctrl.
module swp_dp import swp_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  in_item_t            item,
	input  logic [ACTIVE_W-1:0] active,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output logic                done,
	output out_item_t           result
);

	localparam int IW = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);
	localparam int TW = WEIGHT_BITS + $clog2(SLOTS);

	logic [WEIGHT_BITS-1:0] mem [SLOTS];
	logic [SLOTS-1:0]       valid_q;
	logic [WEIGHT_BITS-1:0] rdata_q;

	logic [63:0]   rng_q;
	logic [63:0]   mul_a_q;
	logic [63:0]   prod_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] sum_q;
	logic [IW-1:0] idx_q;
	logic          done_q;
	out_item_t     result_q;

	logic [IW-1:0] idx_d;
	logic [NW-1:0] n;
	logic [IW-1:0] n_last;
	logic          wr_ok;
	logic [IW-1:0] wr_addr;
	logic          rd_ok;
	logic [TW-1:0] acc_in;
	logic [TW-1:0] sum_nxt;
	logic [63:0]   mul_b;
	logic [31:0]   mul_x;
	logic [31:0]   mul_y;
	logic [63:0]   mul_p;

	assign n       = (32'(active) > SLOTS) ? NW'(SLOTS) : NW'(active);
	assign n_last  = IW'(n - NW'(1));
	assign wr_ok   = (32'(item.slot) < SLOTS);
	assign wr_addr = IW'(item.slot);
	assign acc_in  = TW'(rdata_q);
	assign sum_nxt = sum_q + acc_in;

	always_comb begin
		idx_d = idx_q;
		case (cmd.op) inside
			DP_INIT:         idx_d = '0;
			DP_SUM, DP_SCAN: idx_d = idx_q + IW'(1);
			default:         idx_d = idx_q;
		endcase
	end

	assign rd_ok = (32'(idx_d) < SLOTS);

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WRITE && wr_ok) begin
			mem[wr_addr] <= WEIGHT_BITS'(item.weight);
		end
		rdata_q <= (rd_ok && valid_q[idx_d]) ? mem[idx_d] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.op == DP_WRITE && wr_ok) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		case (cmd.mb)
			MB_MIX_A: mul_b = MIX_MUL_A;
			MB_MIX_B: mul_b = MIX_MUL_B;
			default:  mul_b = 64'(total_q);
		endcase
		case (cmd.mstep)
			MSTEP_LO: begin
				mul_x = mul_a_q[31:0];
				mul_y = mul_b[31:0];
			end
			MSTEP_CROSS_A: begin
				mul_x = mul_a_q[31:0];
				mul_y = mul_b[63:32];
			end
			default: begin
				mul_x = mul_a_q[63:32];
				mul_y = mul_b[31:0];
			end
		endcase
	end

	assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= '0;
		end else begin
			case (cmd.op)
				DP_SEED:    rng_q <= item.seed_value;
				DP_ADVANCE: rng_q <= rng_q + GOLDEN_STEP;
				default:    rng_q <= rng_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		case (cmd.op)
			DP_INIT: begin
				total_q <= '0;
				sum_q   <= '0;
			end
			DP_SUM:       total_q <= total_q + acc_in;
			DP_SCAN:      sum_q <= sum_nxt;
			DP_LOAD_MIX1: mul_a_q <= rng_q ^ (rng_q >> SHIFT_MIX1);
			DP_LOAD_MIX2: mul_a_q <= prod_q ^ (prod_q >> SHIFT_MIX2);
			DP_LOAD_U:    mul_a_q <= (prod_q ^ (prod_q >> SHIFT_MIX3)) >> SHIFT_TOP;
			DP_MUL: begin
				if (cmd.mstep == MSTEP_LO) begin
					prod_q <= mul_p;
				end else begin
					prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == DP_EMIT_EMPTY) || (cmd.op == DP_EMIT_PICK);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_EMIT_EMPTY) begin
			result_q.picked_index <= 4'd0;
			result_q.empty_table  <= 1'b1;
		end else if (cmd.op == DP_EMIT_PICK) begin
			result_q.picked_index <= 4'(idx_q);
			result_q.empty_table  <= 1'b0;
		end
	end

	assign status.n_zero     = (n == '0);
	assign status.at_last    = (idx_q == n_last);
	assign status.total_zero = (total_q == '0);
	assign status.scan_stop  = (prod_q <= (64'(sum_nxt) << FRAC_BITS)) || (idx_q == n_last);

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/splitmix_weighted_pick.sv =====
// Top level of the weighted index picker: APB register, controller and datapath.
// Depends on swp_pkg, swp_ctrl and swp_dp.
//
// Channel   Signals                              Transfer
// item      start, busy, item (in_item_t)        start high while busy low
// result    done, result (out_item_t)            done high for one cycle
// config    psel, penable, pwrite, paddr, pwdata  psel & penable & pwrite
//
// Write, seed and unused-kind transactions finish in the accept cycle; busy stays low.
// A draw with n active slots sums their weights by sequential table reads and reports
// an empty table when n or the sum is zero; otherwise it advances the generator, mixes
// it on the three-pass 32x32 multiplier and scans the table to the slot it picks.
// Reset clears the generator state, the weight table valid bits and the register.
// The receiver cannot stall: done marks each result for one cycle only.
module splitmix_weighted_pick import swp_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          item,
	output logic              done,
	output out_item_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic REG_ACTIVE_ENTRIES = 1'b0;

	logic [ACTIVE_W-1:0] active_q;
	logic                reg_sel;
	dp_cmd_t             cmd;
	dp_status_t          status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ACTIVE_ENTRIES);
	assign prdata  = reg_sel ? 32'(active_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			active_q <= pwdata[ACTIVE_W-1:0];
		end
	end

	swp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	swp_dp #(
		.SLOTS       (SLOTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.active (active_q),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule
